// File: sv/plf_pkg.sv
// Package for the pixel line decimal formatter.
// Holds shared types, ASCII constants and register indexes; no dependencies.
package plf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_ERROR = 8'h45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALUE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE = 1'b1;

    // One classified pixel, as it travels from the front end to the back end.
    typedef struct packed {
        logic               err;
        logic               last;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } plf_desc_t;

endpackage

// File: sv/plf_front.sv
// Front end of the pixel line decimal formatter: window registers, range check
// and binary to decimal split. Depends on plf_pkg.
module plf_front
    import plf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [PIXEL_W-1:0]     pixel_value,
    input  logic                   last_in_line,
    output plf_desc_t              desc
);

    logic [PIXEL_W-1:0] min_value_reg, min_value_next;
    logic [PIXEL_W-1:0] max_value_reg, max_value_next;
    logic [1:0]         hund;
    logic [6:0]         rem;
    logic [14:0]        prod;
    logic [3:0]         tens;
    logic [6:0]         tens_x10;
    logic [3:0]         ones;

    always_comb begin
        min_value_next = min_value_reg;
        max_value_next = max_value_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_MIN_VALUE: min_value_next = cfg_wdata[PIXEL_W-1:0];
                REG_MAX_VALUE: max_value_next = cfg_wdata[PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg <= '0;
            max_value_reg <= '1;
        end else begin
            min_value_reg <= min_value_next;
            max_value_reg <= max_value_next;
        end
    end

    // Hundreds by two compares, tens by a reciprocal multiply that is exact
    // for every remainder below 100.
    always_comb begin
        if (pixel_value >= 8'd200) begin
            hund = 2'd2;
            rem  = 7'(pixel_value - 8'd200);
        end else if (pixel_value >= 8'd100) begin
            hund = 2'd1;
            rem  = 7'(pixel_value - 8'd100);
        end else begin
            hund = 2'd0;
            rem  = pixel_value[6:0];
        end
        prod     = 15'(rem) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        ones     = 4'(rem - tens_x10);
    end

    always_comb begin
        desc.err  = (pixel_value < min_value_reg) || (pixel_value > max_value_reg);
        desc.last = last_in_line;
        desc.hund = {2'b00, hund};
        desc.tens = tens;
        desc.ones = ones;
    end

endmodule

// File: sv/plf_queue.sv
// Short descriptor queue between front and back end of the formatter.
// Depends on plf_pkg.
module plf_queue
    import plf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  plf_desc_t push_desc,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output plf_desc_t pop_desc
);

    plf_desc_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_desc  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: sv/plf_back.sv
// Back end of the formatter: walks one descriptor through its characters and
// drives the registered output channel. Depends on plf_pkg.
module plf_back
    import plf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  plf_desc_t         q_desc,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_out_char,
    output logic              m_run_end
);

    typedef enum logic [6:0] {
        ST_HUND  = 7'b0000001,
        ST_TENS  = 7'b0000010,
        ST_ONES  = 7'b0000100,
        ST_ERR   = 7'b0001000,
        ST_SPACE = 7'b0010000,
        ST_LF    = 7'b0100000,
        ST_CR    = 7'b1000000
    } plf_step_t;

    plf_step_t         step_reg, step_next;
    plf_desc_t         desc_reg, desc_next;
    logic              busy_reg, busy_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_out_char_reg, m_out_char_next;
    logic              m_run_end_reg, m_run_end_next;
    logic              out_adv;
    logic              final_char;
    logic [CHAR_W-1:0] cur_char;
    plf_step_t         after_step;

    assign out_adv = !m_valid_reg || m_ready;

    always_comb begin
        final_char = 1'b0;
        after_step = step_reg;
        cur_char   = CH_SPACE;
        case (step_reg)
            ST_HUND: begin
                cur_char   = CH_ZERO + CHAR_W'(desc_reg.hund);
                after_step = ST_TENS;
            end
            ST_TENS: begin
                cur_char   = CH_ZERO + CHAR_W'(desc_reg.tens);
                after_step = ST_ONES;
            end
            ST_ONES: begin
                cur_char   = CH_ZERO + CHAR_W'(desc_reg.ones);
                after_step = ST_SPACE;
            end
            ST_ERR: begin
                cur_char   = CH_ERROR;
                after_step = ST_SPACE;
            end
            ST_SPACE: begin
                cur_char   = CH_SPACE;
                after_step = ST_LF;
                final_char = !desc_reg.last;
            end
            ST_LF: begin
                cur_char   = CH_LF;
                after_step = ST_CR;
            end
            ST_CR: begin
                cur_char   = CH_CR;
                final_char = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        step_next       = step_reg;
        desc_next       = desc_reg;
        busy_next       = busy_reg;
        m_valid_next    = m_valid_reg;
        m_out_char_next = m_out_char_reg;
        m_run_end_next  = m_run_end_reg;
        q_pop           = 1'b0;
        if (out_adv) begin
            m_valid_next    = busy_reg;
            m_out_char_next = cur_char;
            m_run_end_next  = final_char;
            if (busy_reg && !final_char) begin
                step_next = after_step;
            end else begin
                // The next descriptor is loaded in the cycle that emits the
                // final character, so characters leave without a gap.
                q_pop     = q_not_empty;
                busy_next = q_not_empty;
                desc_next = q_desc;
                step_next = q_desc.err ? ST_ERR : ST_HUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            step_reg    <= ST_HUND;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg       <= desc_next;
        m_out_char_reg <= m_out_char_next;
        m_run_end_reg  <= m_run_end_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_run_end  = m_run_end_reg;

endmodule

// File: sv/pixel_line_decimal_formatter.sv
// Top level of the pixel line decimal formatter.
// Instantiates plf_front, plf_queue and plf_back; depends on plf_pkg.
//
// Usage: each pixel sample transferred on the s_ channel becomes a run of
// ASCII characters on the m_ channel, one character per transfer. A sample
// inside the window [min_value, max_value] gives three decimal digits with
// leading zeros, a sample outside it gives 'E'; a space follows. When
// s_last_in_line is set, a line feed and a carriage return are appended.
// m_run_end marks the last character of each run.
// The window registers are written through cfg_wen, cfg_index and cfg_wdata
// (index 0 is min_value, index 1 is max_value) while no run is in flight.
// When the back end is free, a sample passes through a queue entry, the
// descriptor register and the output register before its first character is
// valid. Throughput: one character per cycle while m_ready is high; a run
// has four characters (two for an 'E' run, plus two when the line ends). The
// back end loads the next item in the same cycle as the final character of
// the current one, so queued runs follow gaplessly. A two-entry queue
// between front and back end buffers samples while a run is being sent;
// once it is full, for instance behind a stalled receiver, s_ready drops.
// Reset empties the queue, clears m_valid and sets the window to 0..255.
module pixel_line_decimal_formatter
    import plf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PIXEL_W-1:0]     s_pixel_value,
    input  logic                   s_last_in_line,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CHAR_W-1:0]      m_out_char,
    output logic                   m_run_end
);

    plf_desc_t front_desc;
    plf_desc_t q_desc;
    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;

    // The front end classifies the sample combinationally; the queue
    // registers the result on the input transfer.
    plf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .pixel_value  (s_pixel_value),
        .last_in_line (s_last_in_line),
        .desc         (front_desc)
    );

    assign s_ready = !q_full;

    plf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_desc (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_desc  (q_desc)
    );

    plf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_desc      (q_desc),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_run_end   (m_run_end)
    );

endmodule

// File: sv/plf_checker.sv
// Port-level checker for the pixel line decimal formatter, with its bind.
// Depends on plf_pkg.
module plf_checker
    import plf_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAR_W-1:0] m_out_char,
    input logic              m_run_end
);

    // The output channel is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled character is held until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_run_end))
        else $error("stalled output changed");

    // A carriage return always closes a run.
    a_cr_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_char == CH_CR) |-> m_run_end)
        else $error("carriage return without run end");

    // Only a space or a carriage return can close a run.
    a_end_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_end |-> (m_out_char == CH_SPACE) || (m_out_char == CH_CR))
        else $error("run ended on wrong character");

    // An error mark is always followed by the space.
    a_err_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_out_char == CH_ERROR) |=>
            m_valid && (m_out_char == CH_SPACE))
        else $error("error mark not followed by space");

endmodule

bind pixel_line_decimal_formatter plf_checker u_plf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_char (m_out_char),
    .m_run_end  (m_run_end)
);

// File: sim/tb.sv
// Self-checking testbench for pixel_line_decimal_formatter.
// Drives random and directed pixel transfers and checks every character;
// depends on plf_pkg and the formatter RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plf_pkg::*;

    // Several times the worst case for roughly 500 pixels plus the long stall.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PIXELS   = 60;
    localparam int MAX_IDLE       = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_LIMIT   = 10;

    // One expected character on the output channel.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              run_end;
    } char_rec_t;

    // Holds the characters that accepted pixels must still produce and
    // compares each output transfer against the oldest one.
    class char_scoreboard;
        char_rec_t pending_chars[$];
        int        mismatches;
        int        pixels_seen;
        int        chars_checked;

        // Formats one accepted pixel against the current window and queues
        // the run of characters it has to produce.
        function void note_pixel(logic [PIXEL_W-1:0] pix, logic last,
                                 logic [PIXEL_W-1:0] lo, logic [PIXEL_W-1:0] hi);
            logic [CHAR_W-1:0] run_chars[$];
            char_rec_t         rec;
            run_chars = {};
            // An inverted window (lo > hi) rejects every sample on its own.
            if (pix < lo || pix > hi) begin
                run_chars.push_back(CH_ERROR);
            end else begin
                run_chars.push_back(CH_ZERO + CHAR_W'(pix / 100));
                run_chars.push_back(CH_ZERO + CHAR_W'((pix / 10) % 10));
                run_chars.push_back(CH_ZERO + CHAR_W'(pix % 10));
            end
            run_chars.push_back(CH_SPACE);
            if (last) begin
                run_chars.push_back(CH_LF);
                run_chars.push_back(CH_CR);
            end
            for (int i = 0; i < run_chars.size(); i++) begin
                rec.ch      = run_chars[i];
                rec.run_end = (i == run_chars.size() - 1);
                pending_chars.push_back(rec);
            end
            pixels_seen++;
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic run_end);
            char_rec_t want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected character 0x%02h run_end=%0b", ch, run_end);
                return;
            end
            want = pending_chars.pop_front();
            if (want.ch !== ch || want.run_end !== run_end) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: char expected 0x%02h run_end=%0b, got 0x%02h run_end=%0b",
                             want.ch, want.run_end, ch, run_end);
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [PIXEL_W-1:0]     s_pixel_value;
    logic                   s_last_in_line;
    logic                   m_valid;
    logic                   m_ready;
    logic [CHAR_W-1:0]      m_out_char;
    logic                   m_run_end;

    // Shadow copy of the window registers, updated when the testbench
    // writes them. Writes only happen while the block is idle, so every
    // pixel is formatted against the window it was accepted under.
    logic [PIXEL_W-1:0] win_min;
    logic [PIXEL_W-1:0] win_max;

    // Idle controls for the two sides; a phase may switch either off.
    bit send_idle;
    bit recv_idle;
    // Set by the main sequence to ask the receiver for one long stall.
    bit hold_req;

    int cycle_count;
    int window_count;

    char_scoreboard sb = new();

    pixel_line_decimal_formatter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_value  (s_pixel_value),
        .s_last_in_line (s_last_in_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_run_end      (m_run_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a lost character or a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Every signal that the testbench or the block drives changes through a
    // nonblocking assignment, so the values read right after the edge are
    // the ones that decided the transfer at that edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_pixel(s_pixel_value, s_last_in_line, win_min, win_max);
        if (aresetn && m_valid && m_ready)
            sb.check_char(m_out_char, m_run_end);
    end

    // Receiver: draws a wait before each character while recv_idle is set, and
    // once, on hold_req, holds m_ready low for a long stretch so that the
    // internal queue fills and the block has to drop s_ready.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Offers one pixel and returns at the edge where it is transferred.
    // When the next pixel follows with no gap, valid simply stays high.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pixel_value  <= pix;
        s_last_in_line <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Closes a phase: stop offering pixels, wait until every queued character
    // has come out, then let the pipeline settle.
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both window registers on back-to-back cycles while idle.
    task automatic set_window(input logic [PIXEL_W-1:0] lo, input logic [PIXEL_W-1:0] hi);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_MIN_VALUE;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_MAX_VALUE;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        win_min = lo;
        win_max = hi;
        window_count++;
        @(posedge aclk);
    endtask

    // Random sample biased toward the window edges and the ends of the range,
    // since that is where the in/out decision can go wrong.
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            5:       return win_min;
            6:       return win_max;
            7:       return win_min - 8'd1;
            8:       return win_max + 8'd1;
            9:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [PIXEL_W-1:0] lo;
        logic [PIXEL_W-1:0] hi;
        logic [PIXEL_W-1:0] tmp;

        aresetn        = 1'b0;
        cfg_wen        = 1'b0;
        cfg_index      = REG_MIN_VALUE;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_pixel_value  = '0;
        s_last_in_line = 1'b0;
        win_min        = 8'd0;
        win_max        = 8'd255;
        send_idle      = 1'b1;
        recv_idle      = 1'b1;
        hold_req       = 1'b0;
        cycle_count    = 0;
        window_count   = 1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. First the reset window 0..255: digit extremes,
        // leading zeros and the carry points of each decimal position.
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd7,   1'b1);
        send_pixel(8'd9,   1'b0);
        send_pixel(8'd10,  1'b0);
        send_pixel(8'd99,  1'b1);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd199, 1'b0);
        send_pixel(8'd255, 1'b1);
        finish_phase();

        // A window in the middle: each side of both bounds.
        set_window(8'd100, 8'd200);
        send_pixel(8'd99,  1'b0);
        send_pixel(8'd100, 1'b1);
        send_pixel(8'd150, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd201, 1'b1);
        finish_phase();

        // Inverted window: nothing is inside, every sample gives the error
        // character, including the two bound values themselves.
        set_window(8'd200, 8'd100);
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd150, 1'b1);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd255, 1'b1);
        finish_phase();

        // Single-value window.
        set_window(8'd37, 8'd37);
        send_pixel(8'd36, 1'b0);
        send_pixel(8'd37, 1'b1);
        send_pixel(8'd38, 1'b0);
        finish_phase();

        // Random part. The first phases pin the window to its extremes, the
        // rest draw it at random; the last one is inverted on purpose.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin lo = 8'd0;   hi = 8'd255; end
                1: begin lo = 8'd0;   hi = 8'd0;   end
                2: begin lo = 8'd255; hi = 8'd255; end
                3: begin lo = 8'd255; hi = 8'd0;   end
                default: begin
                    lo = PIXEL_W'($urandom_range(0, 255));
                    hi = PIXEL_W'($urandom_range(0, 255));
                    if ((lo > hi) != (p == RANDOM_PHASES - 1)) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
            endcase
            set_window(lo, hi);

            // Phase 4 runs back to back on both sides. Phase 5 keeps the
            // sender busy while the receiver stalls for a long time.
            send_idle = (p != 4) && (p != 5);
            recv_idle = (p != 4);
            if (p == 5)
                hold_req = 1'b1;

            for (int i = 0; i < PHASE_PIXELS; i++)
                send_pixel(pick_pixel(), $urandom_range(0, 5) == 0);
            finish_phase();
        end

        $display("Checked %0d pixels and %0d characters under %0d window settings,",
                 sb.pixels_seen, sb.chars_checked, window_count);
        $display("including reset, full, single-value and inverted windows and a long stall.");
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d characters missing", sb.mismatches,
                     sb.outstanding());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/plf_pkg.sv
sv/plf_front.sv
sv/plf_queue.sv
sv/plf_back.sv
sv/pixel_line_decimal_formatter.sv
sv/plf_checker.sv
sim/tb.sv
